FILE: rtl/core/l0exp_pkg.sv
`timescale 1ns / 1ps
// package: types, constants and codes of the level-0 record expander
package l0exp_pkg;

  localparam int unsigned MAX_RECORD_LENGTH = 13864;

  localparam logic [13:0] MIN_LEN     = 14'd13735;
  localparam logic [13:0] MAX_LEN     = 14'(MAX_RECORD_LENGTH);
  localparam logic [13:0] ID_START    = 14'd5;
  localparam logic [13:0] TT_START    = 14'd10;
  localparam logic [13:0] SOH_START   = 14'd15;
  localparam logic [13:0] BODY_START  = 14'd790;
  localparam logic [13:0] BODY_GROUPS = 14'd2589;
  localparam logic [13:0] BODY_END    = BODY_START + 14'd5 * BODY_GROUPS;
  localparam logic [30:0] CNT_MAX     = 31'h7FFF_FFFF;

  localparam logic [13:0] RESET_RECORD_LENGTH = 14'd13860;
  localparam logic [30:0] RESET_FIRST_RECORD  = 31'd1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_RECORD  = 2'd1;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ZERO3,
    CMD_COPY,
    CMD_GROUP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [39:0] data;
    logic        first_two;
    logic        pad;
  } l0exp_cmd_t;

  typedef struct packed {
    logic       valid;
    l0exp_cmd_t cmd;
  } l0exp_push_t;

endpackage

FILE: rtl/core/l0exp_if.sv
`timescale 1ns / 1ps
// channel interfaces: input bytes, output bytes and register writes
interface l0exp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface l0exp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       record_end;
  modport source (output valid, output out_byte, output run_last, output record_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input record_end,
                  output ready);
endinterface

interface l0exp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [30:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/packed_10bit_frame_to_level0_expander.sv
`timescale 1ns / 1ps
// top level: packed 10-bit frame to level-0 record expander
// the first output byte of a request passes through the command queue and the output register
// throughput: one output byte per cycle from the back end while the output is ready;
//   requests are taken every cycle while the 4-entry command queue has room, and
//   the packed body gives 8 output bytes per 5 input bytes
// reset: asynchronous, active low; clears position, counters, queue and output
//   stage, and loads record_length 13860 and first_record 1
module packed_10bit_frame_to_level0_expander (
  input  logic       clk_i,
  input  logic       rst_ni,
  l0exp_in_if.sink   req_i,
  l0exp_cfg_if.sink  cfg_i,
  l0exp_out_if.source rsp_o
);
  import l0exp_pkg::*;

  l0exp_push_t push;
  l0exp_cmd_t  head;
  logic        full;
  logic        head_valid;
  logic        pop;

  l0exp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cfg_i  (cfg_i),
    .full_i (full),
    .push_o (push)
  );

  l0exp_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  l0exp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .rsp_o        (rsp_o)
  );

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !full)
    else $error("command pushed into full queue");

  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("command popped from empty queue");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.record_end) |-> rsp_o.run_last)
    else $error("record end not on last byte of request");

endmodule

FILE: rtl/core/l0exp_front.sv
`timescale 1ns / 1ps
// front end: record position tracking, group assembly and command issue
module l0exp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  l0exp_in_if.sink              req_i,
  l0exp_cfg_if.sink             cfg_i,
  input  logic                  full_i,
  output l0exp_pkg::l0exp_push_t push_o
);
  import l0exp_pkg::*;

  logic [13:0] len_q, len_d;
  logic [30:0] first_q, first_d;
  logic [13:0] pos_q, pos_d;
  logic [30:0] rec_q, rec_d;
  logic [31:0] hold_q, hold_d;
  logic [2:0]  phase_q, phase_d;

  logic [13:0] len_eff;
  logic [2:0]  phase_eff;
  logic        accept;
  logic        active;
  logic        in_grp;
  logic        in_copy;
  logic [7:0]  b;
  logic [14:0] pos_inc;

  assign req_i.ready = !full_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = req_i.valid && !full_i;
  assign b           = req_i.in_byte;
  assign pos_inc     = {1'b0, pos_q} + 15'd1;

  always_comb begin
    len_d   = len_q;
    first_d = first_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_RECORD_LENGTH: len_d   = cfg_i.data[13:0];
        CFG_FIRST_RECORD:  first_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (len_q < MIN_LEN) begin
      len_eff = MIN_LEN;
    end else if (len_q > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = len_q;
    end
  end

  always_comb begin
    rec_d = rec_q;
    if (pos_q == 14'd0 && rec_q != CNT_MAX) begin
      rec_d = rec_q + 31'd1;
    end
  end

  assign active  = rec_d >= first_q;
  assign in_grp  = (pos_q >= ID_START && pos_q < SOH_START) ||
                   (pos_q >= BODY_START && pos_q < BODY_END);
  assign in_copy = pos_q >= SOH_START && pos_q < BODY_START;
  assign phase_eff = (pos_q == ID_START || pos_q == TT_START || pos_q == BODY_START) ?
                     3'd0 : phase_q;

  always_comb begin
    hold_d              = hold_q;
    phase_d             = phase_q;
    push_o.valid        = 1'b0;
    push_o.cmd.kind     = CMD_COPY;
    push_o.cmd.data     = {32'd0, b};
    push_o.cmd.first_two = 1'b0;
    push_o.cmd.pad      = 1'b0;
    if (active) begin
      if (pos_q == 14'd0) begin
        push_o.valid    = accept;
        push_o.cmd.kind = CMD_ZERO3;
      end else if (in_grp) begin
        if (phase_eff < 3'd4) begin
          hold_d  = {hold_q[23:0], b};
          phase_d = phase_eff + 3'd1;
        end else begin
          push_o.valid         = accept;
          push_o.cmd.kind      = CMD_GROUP;
          push_o.cmd.data      = {hold_q, b};
          push_o.cmd.first_two = pos_q < TT_START;
          push_o.cmd.pad       = pos_q == BODY_END - 14'd1;
          phase_d              = 3'd0;
          hold_d               = 32'd0;
        end
      end else if (in_copy) begin
        push_o.valid = accept;
      end
    end
    // record wraps
    if (pos_inc >= {1'b0, len_eff}) begin
      pos_d   = 14'd0;
      phase_d = 3'd0;
      hold_d  = 32'd0;
    end else begin
      pos_d = pos_inc[13:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= RESET_RECORD_LENGTH;
      first_q <= RESET_FIRST_RECORD;
      pos_q   <= 14'd0;
      rec_q   <= 31'd0;
      hold_q  <= 32'd0;
      phase_q <= 3'd0;
    end else begin
      len_q   <= len_d;
      first_q <= first_d;
      if (accept) begin
        pos_q   <= pos_d;
        rec_q   <= rec_d;
        hold_q  <= hold_d;
        phase_q <= phase_d;
      end
    end
  end

endmodule

FILE: rtl/core/l0exp_cmd_fifo.sv
`timescale 1ns / 1ps
// command queue between front end and byte emitter
module l0exp_cmd_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  l0exp_pkg::l0exp_push_t push_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   head_valid_o,
  output l0exp_pkg::l0exp_cmd_t  head_o
);
  import l0exp_pkg::*;

  l0exp_cmd_t             mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_q, wr_d;
  logic [FIFO_PTR_W-1:0]  rd_q, rd_d;
  logic [FIFO_CNT_W-1:0]  cnt_q, cnt_d;
  logic                   do_push;
  logic                   do_pop;

  assign full_o       = cnt_q == FIFO_CNT_W'(FIFO_DEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + FIFO_PTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + FIFO_PTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.cmd;
    end
  end

endmodule

FILE: rtl/core/l0exp_back.sv
`timescale 1ns / 1ps
// back end: expands one command into output bytes, one per cycle while the output is ready
module l0exp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  l0exp_pkg::l0exp_cmd_t head_i,
  output logic                  pop_o,
  l0exp_out_if.source           rsp_o
);
  import l0exp_pkg::*;

  logic [3:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       end_q;

  logic [3:0] nbytes;
  logic [3:0] word_bytes;
  logic [1:0] word_sel;
  logic [9:0] word;
  logic [7:0] byte_d;
  logic       last;
  logic       load;

  always_comb begin
    word_bytes = head_i.first_two ? 4'd4 : 4'd8;
    case (head_i.kind)
      CMD_ZERO3: nbytes = 4'd3;
      CMD_COPY:  nbytes = 4'd1;
      CMD_GROUP: nbytes = word_bytes + (head_i.pad ? 4'd2 : 4'd0);
      default:   nbytes = 4'd1;
    endcase
  end

  assign word_sel = (head_i.first_two ? 2'd2 : 2'd0) + idx_q[2:1];

  always_comb begin
    case (word_sel)
      2'd0:    word = head_i.data[39:30];
      2'd1:    word = head_i.data[29:20];
      2'd2:    word = head_i.data[19:10];
      default: word = head_i.data[9:0];
    endcase
  end

  always_comb begin
    case (head_i.kind)
      CMD_COPY: byte_d = head_i.data[7:0];
      CMD_GROUP: begin
        if (idx_q < word_bytes) begin
          byte_d = idx_q[0] ? word[7:0] : {6'd0, word[9:8]};
        end else begin
          byte_d = 8'd0;
        end
      end
      default: byte_d = 8'd0;
    endcase
  end

  assign last  = idx_q == nbytes - 4'd1;
  assign load  = head_valid_i && (!valid_q || rsp_o.ready);
  assign pop_o = load && last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = last ? 4'd0 : idx_q + 4'd1;
      valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 4'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      last_q <= last;
      end_q  <= last && head_i.kind == CMD_GROUP && head_i.pad;
    end
  end

  assign rsp_o.valid      = valid_q;
  assign rsp_o.out_byte   = byte_q;
  assign rsp_o.run_last   = last_q;
  assign rsp_o.record_end = end_q;

endmodule

FILE: sim/packed_10bit_frame_to_level0_expander_test.sv
`timescale 1ns / 1ps
// testbench: frame bytes streamed through the expander, output checked against a local model
module packed_10bit_frame_to_level0_expander_test;
  import l0exp_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned LONG_HOLD     = 600;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       rec_end;
  } l0_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    logic [3:0] n_want;
    logic [7:0] want_byte;
  } step_t;

  logic clk_i;
  logic rst_ni;

  l0exp_in_if  in_ch ();
  l0exp_cfg_if cfg_ch ();
  l0exp_out_if rsp_ch ();

  packed_10bit_frame_to_level0_expander i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_ch),
    .cfg_i  (cfg_ch),
    .rsp_o  (rsp_ch)
  );

  // model state and register copies
  logic [13:0] rec_len;
  logic [30:0] first_rec;
  logic [13:0] pos;
  logic [30:0] rec_num;
  logic [31:0] hold;
  logic [2:0]  phase;

  l0_byte_t    level0_q [$];
  l0_byte_t    byte_run [$];

  int unsigned fail_count;
  int unsigned tx_count;
  int unsigned rx_count;
  int unsigned records_seen;
  int unsigned in_calm;
  int unsigned out_calm;

  // first request of a record, ignored bytes, extreme groups, copied header bytes
  step_t plan [25] = '{
    '{8'hA5, 1'b1, 4'd3, 8'h00},
    '{8'hFF, 1'b1, 4'd0, 8'h00},
    '{8'h00, 1'b1, 4'd0, 8'h00},
    '{8'h80, 1'b1, 4'd0, 8'h00},
    '{8'h01, 1'b1, 4'd0, 8'h00},
    '{8'hFF, 1'b0, 4'd0, 8'h00},
    '{8'hFF, 1'b0, 4'd0, 8'h00},
    '{8'hFF, 1'b0, 4'd0, 8'h00},
    '{8'hFF, 1'b0, 4'd0, 8'h00},
    '{8'hFF, 1'b0, 4'd0, 8'h00},
    '{8'h00, 1'b1, 4'd0, 8'h00},
    '{8'h00, 1'b1, 4'd0, 8'h00},
    '{8'h00, 1'b1, 4'd0, 8'h00},
    '{8'h00, 1'b1, 4'd0, 8'h00},
    '{8'h00, 1'b1, 4'd8, 8'h00},
    '{8'h00, 1'b1, 4'd1, 8'h00},
    '{8'hFF, 1'b1, 4'd1, 8'hFF},
    '{8'h55, 1'b1, 4'd1, 8'h55},
    '{8'hAA, 1'b1, 4'd1, 8'hAA},
    '{8'h01, 1'b1, 4'd1, 8'h01},
    '{8'h80, 1'b1, 4'd1, 8'h80},
    '{8'h7F, 1'b1, 4'd1, 8'h7F},
    '{8'hFE, 1'b1, 4'd1, 8'hFE},
    '{8'h3C, 1'b1, 4'd1, 8'h3C},
    '{8'hC3, 1'b1, 4'd1, 8'hC3}
  };

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #150_000_000;
    $display("packed_10bit_frame_to_level0_expander: mismatch");
    $finish;
  end

  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      calm = $urandom_range(50, 400);
      return 0;
    end
    if (roll < 4) return $urandom_range(8, 24);
    if (roll < 30) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic expand_byte(input logic [7:0] b);
    logic [13:0] eff_len;
    logic [39:0] grp;
    logic [9:0]  w;
    int          k;
    byte_run.delete();
    eff_len = (rec_len < MIN_LEN) ? MIN_LEN : ((rec_len > MAX_LEN) ? MAX_LEN : rec_len);
    if (pos == 14'd0 && rec_num < CNT_MAX) rec_num++;
    if (rec_num >= first_rec) begin
      if (pos == 14'd0) begin
        repeat (3) byte_run.push_back('{8'h00, 1'b0, 1'b0});
      end else if ((pos >= ID_START && pos < SOH_START) ||
                   (pos >= BODY_START && pos < BODY_END)) begin
        if (pos == ID_START || pos == TT_START || pos == BODY_START) phase = 3'd0;
        if (phase < 3'd4) begin
          hold  = {hold[23:0], b};
          phase = phase + 3'd1;
        end else begin
          grp = {hold, b};
          for (k = (pos < TT_START) ? 2 : 0; k < 4; k++) begin
            w = grp[39 - 10*k -: 10];
            byte_run.push_back('{{6'd0, w[9:8]}, 1'b0, 1'b0});
            byte_run.push_back('{w[7:0], 1'b0, 1'b0});
          end
          phase = 3'd0;
          hold  = 32'd0;
          if (pos == BODY_END - 14'd1) begin
            byte_run.push_back('{8'h00, 1'b0, 1'b0});
            byte_run.push_back('{8'h00, 1'b0, 1'b1});
          end
        end
      end else if (pos >= SOH_START && pos < BODY_START) begin
        byte_run.push_back('{b, 1'b0, 1'b0});
      end
    end
    if (byte_run.size() > 0) byte_run[byte_run.size() - 1].last = 1'b1;
    if (int'(pos) + 1 >= int'(eff_len)) begin
      pos   = 14'd0;
      phase = 3'd0;
      hold  = 32'd0;
    end else begin
      pos = pos + 14'd1;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic typed, input logic [3:0] n_want,
                           input logic [7:0] want_byte);
    int unsigned gap;
    int unsigned j;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    tx_count++;
    expand_byte(b);
    if (typed) begin
      byte_run.delete();
      for (j = 0; j < n_want; j++) begin
        byte_run.push_back('{want_byte, (j == n_want - 1), 1'b0});
      end
    end
    for (j = 0; j < byte_run.size(); j++) level0_q.push_back(byte_run[j]);
    @(negedge clk_i);
  endtask

  task automatic stream_bytes(input int unsigned count);
    repeat (count) send_byte(8'($urandom_range(0, 255)), 1'b0, 4'd0, 8'h00);
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (level0_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] value,
                           input logic drop_after);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    if (idx == CFG_RECORD_LENGTH) rec_len = value[13:0];
    else if (idx == CFG_FIRST_RECORD) first_rec = value;
    @(negedge clk_i);
    if (drop_after) cfg_ch.valid <= 1'b0;
  endtask

  // output side: random stalls, a long hold to back up the request path
  initial begin
    l0_byte_t    want;
    int unsigned stall_left;
    rsp_ch.ready <= 1'b0;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
      @(posedge clk_i);
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        rx_count++;
        if (rsp_ch.record_end === 1'b1) records_seen++;
        if (level0_q.size() == 0) begin
          $error("out_byte: expected none, got 0x%02h", rsp_ch.out_byte);
          fail_count++;
        end else begin
          want = level0_q.pop_front();
          if (rsp_ch.out_byte !== want.data) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.data, rsp_ch.out_byte);
            fail_count++;
          end
          if (rsp_ch.run_last !== want.last) begin
            $error("run_last: expected %0b, got %0b", want.last, rsp_ch.run_last);
            fail_count++;
          end
          if (rsp_ch.record_end !== want.rec_end) begin
            $error("record_end: expected %0b, got %0b", want.rec_end, rsp_ch.record_end);
            fail_count++;
          end
        end
        stall_left = pick_gap(out_calm);
        if (rx_count == 20) stall_left = LONG_HOLD;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'h00;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= CFG_RECORD_LENGTH;
    cfg_ch.data   <= 31'd0;
    rec_len      = RESET_RECORD_LENGTH;
    first_rec    = RESET_FIRST_RECORD;
    pos          = 14'd0;
    rec_num      = 31'd0;
    hold         = 32'd0;
    phase        = 3'd0;
    fail_count   = 0;
    tx_count     = 0;
    rx_count     = 0;
    records_seen = 0;
    in_calm      = 0;
    out_calm     = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // start of record 1 at reset settings
    foreach (plan[i]) send_byte(plan[i].data, plan[i].typed, plan[i].n_want, plan[i].want_byte);
    stream_bytes(75);
    quiesce();

    // highest first record drops the rest of the record
    write_reg(CFG_FIRST_RECORD, CNT_MAX, 1'b1);
    stream_bytes(30);
    quiesce();

    // every record converted again, length clamped up to the minimum
    write_reg(CFG_FIRST_RECORD, 31'd0, 1'b0);
    write_reg(CFG_RECORD_LENGTH, 31'd0, 1'b1);
    stream_bytes(40);
    quiesce();

    $display("covered %0d input requests and %0d output bytes, %0d record ends",
             tx_count, rx_count, records_seen);
    $display("record start, header groups, copied bytes, dropping and length clamp");
    if (fail_count == 0) begin
      $display("packed_10bit_frame_to_level0_expander: match");
    end else begin
      $display("packed_10bit_frame_to_level0_expander: mismatch");
    end
    $finish;
  end

endmodule
